[hw/rtl/dllu_pkg.sv]
// shared types and constants for the doubly linked record list unit
package dllu_pkg;

  localparam int MAX_NODES = 16;
  localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  localparam logic [2:0] ACT_INS_HEAD  = 3'd0;
  localparam logic [2:0] ACT_INS_AFTER = 3'd1;
  localparam logic [2:0] ACT_INS_TAIL  = 3'd2;
  localparam logic [2:0] ACT_DEL_HEAD  = 3'd3;
  localparam logic [2:0] ACT_DEL_TAIL  = 3'd4;
  localparam logic [2:0] ACT_DEL_KEY   = 3'd5;
  localparam logic [2:0] ACT_READ_FWD  = 3'd6;
  localparam logic [2:0] ACT_READ_REV  = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_LEFT  = 2'd1;
  localparam logic [1:0] CELL_RIGHT = 2'd2;
  localparam logic [1:0] CELL_NEW   = 2'd3;

  typedef struct packed {
    logic [1:0] op;
  } cell_ctl_t;

  typedef struct packed {
    logic signed [31:0] roll;
    logic [63:0]        name_low;
    logic [7:0]         name_high;
  } rec_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] search_key;
    logic signed [31:0] new_roll;
    logic [63:0]        new_name_low;
    logic [7:0]         new_name_high;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_roll;
    logic [63:0]        out_name_low;
    logic [7:0]         out_name_high;
    logic               last_of_run;
  } out_word_t;

endpackage

[hw/rtl/dllu_cell.sv]
// one list position: holds a record, shifts with its neighbors, compares its roll
module dllu_cell (
  input  logic                  clk,
  input  dllu_pkg::cell_ctl_t   ctl,
  input  dllu_pkg::rec_t        left_rec,
  input  dllu_pkg::rec_t        right_rec,
  input  dllu_pkg::rec_t        new_rec,
  input  logic signed [31:0]    key,
  output dllu_pkg::rec_t        rec,
  output logic                  match
);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      dllu_pkg::CELL_HOLD:  rec <= rec;
      dllu_pkg::CELL_LEFT:  rec <= left_rec;
      dllu_pkg::CELL_RIGHT: rec <= right_rec;
      dllu_pkg::CELL_NEW:   rec <= new_rec;
      default:              rec <= rec;
    endcase
  end

  assign match = (rec.roll == key);

endmodule

[hw/rtl/doubly_linked_record_list_unit.sv]
// top level of the doubly linked record list unit
// The list is kept in list order in a row of MAX_NODES cells, cell 0 the head.
// Inserts and deletes shift the cells where needed and answer with one status
// word. A key search compares all cells at once. Forward and reverse reads
// emit one word per cycle from the cells while the output is not stalled,
// so a read of n records gives n words, up to MAX_NODES; the next item is
// taken once the last word is in the output register. No clearing pass is
// needed after reset.
module doubly_linked_record_list_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dllu_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dllu_pkg::out_word_t out_data
);

  localparam int N  = dllu_pkg::MAX_NODES;
  localparam int IW = dllu_pkg::IDX_W;
  localparam int CW = dllu_pkg::CNT_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic              state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [IW-1:0]     rd_ptr;
  logic              rd_rev;
  logic [CW-1:0]     rd_left;

  dllu_pkg::cell_ctl_t ctl [N];
  dllu_pkg::rec_t      cell_rec [N];
  logic [N-1:0]        match;
  dllu_pkg::rec_t      new_rec;

  logic              take;
  logic              acc;
  logic              found;
  logic [IW-1:0]     pos;
  logic              empty;
  logic              full;
  logic [1:0]        status_next;
  logic              is_read;

  assign take     = out_ready | ~out_valid;
  assign in_ready = (state == S_IDLE) & take;
  assign acc      = in_valid & in_ready;
  assign empty    = (count == '0);
  assign full     = (count == CW'(N));
  assign is_read  = (in_data.action == dllu_pkg::ACT_READ_FWD) ||
                    (in_data.action == dllu_pkg::ACT_READ_REV);

  assign new_rec.roll      = in_data.new_roll;
  assign new_rec.name_low  = in_data.new_name_low;
  assign new_rec.name_high = in_data.new_name_high;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      dllu_cell u_cell (
        .clk       (clk),
        .ctl       (ctl[g]),
        .left_rec  ((g == 0) ? new_rec : cell_rec[(g == 0) ? 0 : g - 1]),
        .right_rec ((g == N - 1) ? cell_rec[g] : cell_rec[(g == N - 1) ? g : g + 1]),
        .new_rec   (new_rec),
        .key       (in_data.search_key),
        .rec       (cell_rec[g]),
        .match     (match[g])
      );
    end
  endgenerate

  // first valid cell whose roll matches the key
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int j = N - 1; j >= 0; j--) begin
      if (match[j] && (CW'(j) < count)) begin
        found = 1'b1;
        pos   = IW'(j);
      end
    end
  end

  // cell shift control and status for the changing actions
  always_comb begin
    status_next = dllu_pkg::ST_OK;
    count_next  = count;
    for (int j = 0; j < N; j++) ctl[j].op = dllu_pkg::CELL_HOLD;
    if (acc && !is_read) begin
      unique case (in_data.action)
        dllu_pkg::ACT_INS_HEAD: begin
          if (full) status_next = dllu_pkg::ST_FULL;
          else begin
            for (int j = 0; j < N; j++)
              ctl[j].op = (j == 0) ? dllu_pkg::CELL_NEW : dllu_pkg::CELL_LEFT;
            count_next = count + CW'(1);
          end
        end
        dllu_pkg::ACT_INS_AFTER: begin
          if (empty) status_next = dllu_pkg::ST_EMPTY;
          else if (!found) status_next = dllu_pkg::ST_NOT_FOUND;
          else if (full) status_next = dllu_pkg::ST_FULL;
          else begin
            for (int j = 0; j < N; j++) begin
              if (CW'(j) == CW'(pos) + CW'(1)) ctl[j].op = dllu_pkg::CELL_NEW;
              else if (CW'(j) > CW'(pos) + CW'(1)) ctl[j].op = dllu_pkg::CELL_LEFT;
            end
            count_next = count + CW'(1);
          end
        end
        dllu_pkg::ACT_INS_TAIL: begin
          if (full) status_next = dllu_pkg::ST_FULL;
          else begin
            for (int j = 0; j < N; j++)
              if (CW'(j) == count) ctl[j].op = dllu_pkg::CELL_NEW;
            count_next = count + CW'(1);
          end
        end
        dllu_pkg::ACT_DEL_HEAD: begin
          if (empty) status_next = dllu_pkg::ST_EMPTY;
          else begin
            for (int j = 0; j < N; j++) ctl[j].op = dllu_pkg::CELL_RIGHT;
            count_next = count - CW'(1);
          end
        end
        dllu_pkg::ACT_DEL_TAIL: begin
          if (empty) status_next = dllu_pkg::ST_EMPTY;
          else count_next = count - CW'(1);
        end
        dllu_pkg::ACT_DEL_KEY: begin
          if (empty) status_next = dllu_pkg::ST_EMPTY;
          else if (!found) status_next = dllu_pkg::ST_NOT_FOUND;
          else begin
            for (int j = 0; j < N; j++)
              if (IW'(j) >= pos) ctl[j].op = dllu_pkg::CELL_RIGHT;
            count_next = count - CW'(1);
          end
        end
        default: status_next = dllu_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      rd_ptr    <= '0;
      rd_rev    <= 1'b0;
      rd_left   <= '0;
    end else begin
      count <= count_next;
      unique case (state)
        S_IDLE: begin
          if (acc && is_read && !empty) begin
            state     <= S_READ;
            out_valid <= 1'b0;
            rd_rev    <= (in_data.action == dllu_pkg::ACT_READ_REV);
            rd_ptr    <= (in_data.action == dllu_pkg::ACT_READ_REV) ?
                         IW'(count - CW'(1)) : '0;
            rd_left   <= count;
          end else if (acc) begin
            out_valid              <= 1'b1;
            out_data.status        <= is_read ? dllu_pkg::ST_EMPTY : status_next;
            out_data.out_roll      <= '0;
            out_data.out_name_low  <= '0;
            out_data.out_name_high <= '0;
            out_data.last_of_run   <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          if (take) begin
            out_valid              <= 1'b1;
            out_data.status        <= dllu_pkg::ST_OK;
            out_data.out_roll      <= cell_rec[rd_ptr].roll;
            out_data.out_name_low  <= cell_rec[rd_ptr].name_low;
            out_data.out_name_high <= cell_rec[rd_ptr].name_high;
            out_data.last_of_run   <= (rd_left == CW'(1));
            rd_ptr                 <= rd_rev ? rd_ptr - IW'(1) : rd_ptr + IW'(1);
            rd_left                <= rd_left - CW'(1);
            if (rd_left == CW'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(N))
    else $error("record count beyond pool size");

  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (count != '0) && (rd_left != '0))
    else $error("read run on empty list");

  a_head_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (acc && in_data.action == dllu_pkg::ACT_INS_HEAD && !full)
      |=> (count == $past(count) + CW'(1)))
    else $error("head insert did not grow the list");

  a_read_holds_list: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> $stable(count))
    else $error("list changed during a read run");
`endif

endmodule
